>>> design/foc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_pkg
// Shared types, constants and the quarter-wave sine table for the current loop.
// ----------------------------------------------------------------------------
package foc_pkg;

  localparam int SineDepth = 1024;
  localparam int AngleBits = 16;
  localparam int IdxBits   = $clog2(SineDepth) + 2;
  localparam int RBits     = $clog2(SineDepth);

  localparam logic [15:0] InvSqrt3Q16  = 16'd37837;
  localparam logic [15:0] Sqrt3HalfQ16 = 16'd56755;

  localparam logic [2:0] CfgDTarget = 3'd0;
  localparam logic [2:0] CfgQTarget = 3'd1;
  localparam logic [2:0] CfgPGain   = 3'd2;
  localparam logic [2:0] CfgIGain   = 3'd3;
  localparam logic [2:0] CfgLimit   = 3'd4;

  typedef struct packed {
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic signed [15:0] phase_c_current;
    logic [15:0]        rotor_angle;
  } foc_in_t;

  typedef struct packed {
    logic signed [15:0] phase_a_voltage;
    logic signed [15:0] phase_b_voltage;
    logic signed [15:0] phase_c_voltage;
    logic signed [15:0] d_current_measured;
    logic signed [15:0] q_current_measured;
  } foc_out_t;

  // table entry, worked out at elaboration only (constant argument)
  function automatic logic [16:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x  = (64'd1686629713 * 64'(k)) / 64'(SineDepth);
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32768) q = 64'd32768;
    return q[16:0];
  endfunction

  typedef logic [16:0] sine_rom_t [SineDepth+1];

  function automatic sine_rom_t build_rom();
    sine_rom_t r;
    for (int k = 0; k <= SineDepth; k++) r[k] = sine_entry(k);
    return r;
  endfunction

  localparam sine_rom_t SineRom = build_rom();

endpackage

>>> design/foc_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_serial_mul
// Shift-add multiplier: signed 41-bit a times unsigned 32-bit b, one bit a cycle.
// ----------------------------------------------------------------------------
module foc_serial_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [40:0]  a,
  input  logic [31:0]         b,
  output logic                done,
  output logic signed [73:0]  prod
);
  import foc_pkg::*;

  logic [31:0]        mcand_b;
  logic signed [73:0] acc;
  logic signed [73:0] addend;
  logic [5:0]         cnt;
  logic               busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= '0;
      addend  <= 74'(a);
      mcand_b <= b;
    end else if (busy) begin
      if (mcand_b[0]) acc <= acc + addend;
      addend  <= addend <<< 1;
      mcand_b <= mcand_b >> 1;
    end
  end

endmodule

>>> design/foc_current_loop_pi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_current_loop_pi_core
// Clarke, Park, d/q PI regulators, inverse Park and inverse Clarke, with all
// products formed one at a time on a bit-serial shift-add multiplier.
// Per request: one sine/cosine table lookup, then 14 products, each issued,
// loaded, formed by serial shift-add, marked done and then post-processed.
// A new request is taken only after the result is accepted, and all products
// share one serial multiplier. Reset restores register defaults and clears both error sums.
// ----------------------------------------------------------------------------
module foc_current_loop_pi_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  foc_pkg::foc_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output foc_pkg::foc_out_t    out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import foc_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTab  = 4'd1;
  localparam logic [3:0] StMul  = 4'd2;
  localparam logic [3:0] StWait = 4'd3;
  localparam logic [3:0] StPost = 4'd4;
  localparam logic [3:0] StOut  = 4'd5;

  logic signed [15:0] d_target;
  logic signed [15:0] q_target;
  logic [15:0]        prop_gain;
  logic [31:0]        int_gain;
  logic [14:0]        out_limit;
  logic signed [39:0] d_sum;
  logic signed [39:0] q_sum;

  logic [3:0]  state;
  logic [3:0]  step;
  foc_in_t     req;
  logic signed [17:0] sn;
  logic signed [17:0] cs;
  logic [16:0]        sn_mag;
  logic [16:0]        cs_mag;
  logic signed [40:0] beta;
  logic signed [40:0] t0;
  logic signed [40:0] md;
  logic signed [40:0] mq;
  logic signed [40:0] err;
  logic signed [40:0] nsum;
  logic signed [40:0] pterm;
  logic signed [40:0] ud;
  logic signed [40:0] uq;
  logic signed [40:0] va;
  logic signed [40:0] vb;

  logic               mstart;
  logic               mdone;
  logic signed [40:0] ma;
  logic [31:0]        mb;
  logic               mneg;
  logic signed [73:0] mprod;
  logic signed [73:0] p;

  foc_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
    .done(mdone), .prod(mprod)
  );

  assign in_ready = (state == StIdle);
  assign p = mneg ? -mprod : mprod;

  // magnitudes of sine and cosine for the unsigned multiplier operand
  assign sn_mag = sn[17] ? 17'(-sn) : sn[16:0];
  assign cs_mag = cs[17] ? 17'(-cs) : cs[16:0];

  // angle to table index
  logic [IdxBits-1:0] idx_s;
  logic [IdxBits-1:0] idx_c;
  assign idx_s = IdxBits'(({8'd0, req.rotor_angle[AngleBits-1:0]} * (4 * SineDepth))
                 >> AngleBits);
  assign idx_c = idx_s + IdxBits'(SineDepth);

  function automatic logic signed [17:0] wave(input logic [IdxBits-1:0] i);
    logic [1:0]       quad;
    logic [RBits-1:0] r;
    logic [16:0]      v;
    quad = i[IdxBits-1 -: 2];
    r    = i[RBits-1:0];
    unique case (quad)
      2'd0:    v = SineRom[r];
      2'd1:    v = SineRom[SineDepth - int'(r)];
      2'd2:    v = SineRom[r];
      default: v = SineRom[SineDepth - int'(r)];
    endcase
    return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [40:0] rshr(input logic signed [73:0] v,
                                              input int n);
    logic signed [73:0] t;
    t = (v + (74'sd1 <<< (n - 1))) >>> n;
    return t[40:0];
  endfunction

  function automatic logic signed [40:0] sat16(input logic signed [40:0] v);
    if (v > 41'sd32767) return 41'sd32767;
    if (v < -41'sd32768) return -41'sd32768;
    return v;
  endfunction

  function automatic logic signed [40:0] sat40(input logic signed [40:0] v);
    if (v > 41'sd549755813887) return 41'sd549755813887;
    if (v < -41'sd549755813888) return -41'sd549755813888;
    return v;
  endfunction

  // operand select for each product step
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    unique case (step)
      4'd0:  begin ma = 41'(req.phase_b_current) - 41'(req.phase_c_current);
                   mb = 32'(InvSqrt3Q16); end
      4'd1:  begin ma = 41'(req.phase_a_current); mb = 32'(cs_mag); mneg = cs[17]; end
      4'd2:  begin ma = beta; mb = 32'(sn_mag); mneg = sn[17]; end
      4'd3:  begin ma = beta; mb = 32'(cs_mag); mneg = cs[17]; end
      4'd4:  begin ma = 41'(req.phase_a_current); mb = 32'(sn_mag); mneg = sn[17]; end
      4'd5:  begin ma = err; mb = 32'(prop_gain); end
      4'd6:  begin ma = nsum; mb = int_gain; end
      4'd7:  begin ma = err; mb = 32'(prop_gain); end
      4'd8:  begin ma = nsum; mb = int_gain; end
      4'd9:  begin ma = ud; mb = 32'(cs_mag); mneg = cs[17]; end
      4'd10: begin ma = uq; mb = 32'(sn_mag); mneg = sn[17]; end
      4'd11: begin ma = ud; mb = 32'(sn_mag); mneg = sn[17]; end
      4'd12: begin ma = uq; mb = 32'(cs_mag); mneg = cs[17]; end
      4'd13: begin ma = vb; mb = 32'(Sqrt3HalfQ16); end
      default: ;
    endcase
  end

  logic signed [40:0] lim;
  logic signed [40:0] pi_out;
  assign lim    = 41'($signed({1'b0, out_limit}));
  assign pi_out = pterm + rshr(mprod, 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
      mstart    <= 1'b0;
      step      <= '0;
      d_target  <= 16'sd0;
      q_target  <= 16'sd768;
      prop_gain <= 16'd819;
      int_gain  <= 32'd8590;
      out_limit <= 15'd25600;
      d_sum     <= '0;
      q_sum     <= '0;
    end else begin
      mstart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgDTarget: d_target  <= cfg_data[15:0];
          CfgQTarget: q_target  <= cfg_data[15:0];
          CfgPGain:   prop_gain <= cfg_data[15:0];
          CfgIGain:   int_gain  <= cfg_data;
          CfgLimit:   out_limit <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state)
        StIdle: begin
          if (in_valid) begin
            req   <= in_data;
            step  <= '0;
            state <= StTab;
          end
        end
        StTab: begin
          sn     <= wave(idx_s);
          cs     <= wave(idx_c);
          state  <= StMul;
        end
        StMul: begin
          mstart <= 1'b1;
          state  <= StWait;
        end
        StWait: begin
          if (mdone) state <= StPost;
        end
        StPost: begin
          state <= (step == 4'd13) ? StOut : StMul;
          step  <= step + 4'd1;
          unique case (step)
            4'd0:  beta <= rshr(mprod, 16);
            4'd1:  t0 <= p[40:0];
            4'd2:  begin
              md  <= sat16(rshr(74'(t0) + p, 15));
              err <= 41'(d_target) - sat16(rshr(74'(t0) + p, 15));
            end
            4'd3:  t0 <= p[40:0];
            4'd4:  mq <= sat16(rshr(74'(t0) - p, 15));
            4'd5:  begin
              pterm <= rshr(mprod, 12);
              nsum  <= sat40(41'(d_sum) + err);
            end
            4'd6:  begin
              if (pi_out > lim) ud <= lim;
              else if (pi_out < -lim) ud <= -lim;
              else begin ud <= pi_out; d_sum <= nsum[39:0]; end
              err <= 41'(q_target) - mq;
            end
            4'd7:  begin
              pterm <= rshr(mprod, 12);
              nsum  <= sat40(41'(q_sum) + err);
            end
            4'd8:  begin
              if (pi_out > lim) uq <= lim;
              else if (pi_out < -lim) uq <= -lim;
              else begin uq <= pi_out; q_sum <= nsum[39:0]; end
            end
            4'd9:  t0 <= p[40:0];
            4'd10: va <= rshr(74'(t0) - p, 15);
            4'd11: t0 <= p[40:0];
            4'd12: vb <= rshr(74'(t0) + p, 15);
            4'd13: begin
              out_data.phase_a_voltage    <= 16'(sat16(va));
              out_data.phase_b_voltage    <= 16'(sat16(rshr(-(74'(va) <<< 15) + mprod, 16)));
              out_data.phase_c_voltage    <= 16'(sat16(rshr(-(74'(va) <<< 15) - mprod, 16)));
              out_data.d_current_measured <= md[15:0];
              out_data.q_current_measured <= mq[15:0];
              out_valid <= 1'b1;
            end
            default: ;
          endcase
        end
        StOut: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == StOut) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

>>> tb/foc_current_loop_pi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_current_loop_pi_checker
// Watches the request and result channels of the current loop core, keeps its
// own copy of the registers and both error sums, works out the expected phase
// voltages and measured d/q currents per request and compares them in order.
// ----------------------------------------------------------------------------
module foc_current_loop_pi_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  foc_pkg::foc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  foc_pkg::foc_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending
);
  import foc_pkg::*;

  localparam longint SumMax = 64'sd549755813887;
  localparam longint SumMin = -SumMax - 1;

  logic signed [15:0] d_target, q_target;
  logic [15:0]        p_gain;
  logic [31:0]        i_gain;
  logic [14:0]        v_limit;
  longint             d_sum, q_sum;
  longint             sine_tab [SineDepth+1];
  foc_out_t           voltage_q[$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_sine(int k);
    longint unsigned x, x2, t, s, q;
    x  = (64'd1686629713 * longint'(k)) / SineDepth;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    q  = (s + 64'd16384) >> 15;
    return q > 32768 ? 32768 : longint'(q);
  endfunction

  function automatic longint wave_at(longint unsigned i);
    longint unsigned quad, r;
    i    = i % (4 * SineDepth);
    quad = i / SineDepth;
    r    = i % SineDepth;
    case (quad)
      0: return sine_tab[r];
      1: return sine_tab[SineDepth - r];
      2: return -sine_tab[r];
      default: return -sine_tab[SineDepth - r];
    endcase
  endfunction

  function automatic longint regulate(ref longint acc, input longint err);
    longint p, ns, a, b, o;
    p  = round_shift(longint'(p_gain) * err, 12);
    ns = clip(acc + err, SumMin, SumMax);
    a  = ns * longint'(i_gain[31:16]);
    b  = ns * longint'(i_gain[15:0]) + (64'sd1 <<< 31);
    o  = p + floor_shift(a + floor_shift(b, 16), 16);
    if (o > longint'(v_limit)) return longint'(v_limit);
    if (o < -longint'(v_limit)) return -longint'(v_limit);
    acc = ns;
    return o;
  endfunction

  function automatic foc_out_t loop_step(foc_in_t req);
    longint unsigned idx;
    longint sn, cs, al, be, md, mq, ud, uq, va, vb;
    foc_out_t r;
    idx = (longint'(req.rotor_angle) * 4 * SineDepth) >> AngleBits;
    sn  = wave_at(idx);
    cs  = wave_at(idx + SineDepth);
    al  = req.phase_a_current;
    be  = round_shift((longint'(req.phase_b_current) - req.phase_c_current) * 37837, 16);
    md  = clip(round_shift(cs * al + sn * be, 15), -32768, 32767);
    mq  = clip(round_shift(cs * be - sn * al, 15), -32768, 32767);
    ud  = regulate(d_sum, longint'(d_target) - md);
    uq  = regulate(q_sum, longint'(q_target) - mq);
    va  = round_shift(cs * ud - sn * uq, 15);
    vb  = round_shift(sn * ud + cs * uq, 15);
    r.phase_a_voltage    = 16'(clip(va, -32768, 32767));
    r.phase_b_voltage    = 16'(clip(round_shift(-32768 * va + 56755 * vb, 16), -32768, 32767));
    r.phase_c_voltage    = 16'(clip(round_shift(-32768 * va - 56755 * vb, 16), -32768, 32767));
    r.d_current_measured = 16'(md);
    r.q_current_measured = 16'(mq);
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    for (int k = 0; k <= SineDepth; k++) sine_tab[k] = quarter_sine(k);
  end

  assign pending = voltage_q.size();

  always @(posedge clk) begin
    foc_out_t w;
    if (rst) begin
      d_target <= 16'sd0;
      q_target <= 16'sd768;
      p_gain   <= 16'd819;
      i_gain   <= 32'd8590;
      v_limit  <= 15'd25600;
      d_sum    = 0;
      q_sum    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgDTarget: d_target <= cfg_data[15:0];
          CfgQTarget: q_target <= cfg_data[15:0];
          CfgPGain:   p_gain   <= cfg_data[15:0];
          CfgIGain:   i_gain   <= cfg_data;
          CfgLimit:   v_limit  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) voltage_q.push_back(loop_step(in_data));
      if (out_valid && out_ready) begin
        if (voltage_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          w = voltage_q.pop_front();
          if (out_data.phase_a_voltage !== w.phase_a_voltage)
            report("phase_a_voltage", out_data.phase_a_voltage, w.phase_a_voltage);
          if (out_data.phase_b_voltage !== w.phase_b_voltage)
            report("phase_b_voltage", out_data.phase_b_voltage, w.phase_b_voltage);
          if (out_data.phase_c_voltage !== w.phase_c_voltage)
            report("phase_c_voltage", out_data.phase_c_voltage, w.phase_c_voltage);
          if (out_data.d_current_measured !== w.d_current_measured)
            report("d_current_measured", out_data.d_current_measured, w.d_current_measured);
          if (out_data.q_current_measured !== w.q_current_measured)
            report("q_current_measured", out_data.q_current_measured, w.q_current_measured);
        end
      end
    end
  end

endmodule

>>> tb/foc_current_loop_pi_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_current_loop_pi_core_tb
// Drives phase current requests through the current loop core under several
// register settings with random idling on both sides; the checker compares
// every result and the top gives the verdict.
// ----------------------------------------------------------------------------
module foc_current_loop_pi_core_tb;
  import foc_pkg::*;

  localparam int CycleLimit = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  foc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  foc_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CfgDTarget;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  int          cycles = 0;
  bit          calm = 1'b0;

  always #1 clk = ~clk;

  foc_current_loop_pi_core u_dut (.*);

  foc_current_loop_pi_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("foc_current_loop_pi_core verification failed");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(posedge clk);
      end else out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic send_request(foc_in_t req);
    int n;
    cfg_we <= 1'b0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic foc_in_t random_request(bit wide);
    foc_in_t r;
    if (wide) begin
      r.phase_a_current = edge_val();
      r.phase_b_current = edge_val();
      r.phase_c_current = edge_val();
    end else begin
      r.phase_a_current = 16'($signed($urandom_range(0, 4096)) - 2048);
      r.phase_b_current = 16'($signed($urandom_range(0, 4096)) - 2048);
      r.phase_c_current = -(r.phase_a_current + r.phase_b_current);
    end
    r.rotor_angle = 16'($urandom);
    return r;
  endfunction

  task automatic random_settings(int phase);
    write_reg(CfgDTarget, 32'($urandom));
    write_reg(CfgQTarget, 32'($urandom));
    write_reg(CfgPGain, phase == 1 ? 32'hffff : 32'($urandom_range(0, 8192)));
    write_reg(CfgIGain, phase == 1 ? 32'hffffffff : (phase == 2 ? 32'd0 : $urandom));
    write_reg(CfgLimit, phase == 2 ? 32'h7fff : (phase == 3 ? 32'd0 :
                        32'($urandom_range(0, 32767))));
    write_reg(3'd7, $urandom);
  endtask

  initial begin
    foc_in_t r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, quadrant boundaries and clamping at default gains
    for (int i = 0; i < 20; i++) begin
      r.phase_a_current = i[0] ? 16'h7fff : 16'h8000;
      r.phase_b_current = i[1] ? 16'h7fff : 16'h8000;
      r.phase_c_current = i[2] ? 16'h8000 : 16'h0000;
      r.rotor_angle     = 16'(i * 16384 / 4) ^ (i > 15 ? 16'hffff : 16'h0);
      send_request(r);
    end
    drain();
    write_reg(CfgLimit, 32'd0);
    write_reg(CfgIGain, 32'hffffffff);
    for (int i = 0; i < 4; i++) send_request(random_request(1'b1));
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      random_settings(phase);
      if (phase == 7) calm = 1'b1;
      for (int i = 0; i < 115; i++) send_request(random_request($urandom_range(0, 3) == 0));
      drain();
    end
    if (errors == 0)
      $display("foc_current_loop_pi_core verification clean");
    else
      $display("foc_current_loop_pi_core verification failed");
    $finish;
  end

endmodule

>>> files.f
design/foc_pkg.sv
design/foc_serial_mul.sv
design/foc_current_loop_pi_core.sv
tb/foc_current_loop_pi_checker.sv
tb/foc_current_loop_pi_core_tb.sv
